/* rtl/jhg_pkg.sv */
`default_nettype none
// ============================================================================
// jhg_pkg: shared constants and types of the Jacobi heat grid solver
// Field widths, request and result codes, register indexes, reset values
// and the control word that the sequencer hands to the stencil datapath.
// ============================================================================
package jhg_pkg;

	localparam int GRID_SIZE_DEF = 16;

	localparam int CELL_W   = 32;
	localparam int SUM_W    = 34;
	localparam int CNT_W    = 16;
	localparam int CFG_W    = 16;
	localparam int RC_W     = 4;
	localparam int ACT_W    = 2;
	localparam int CFG_IDX_W = 1;
	localparam int PH_W     = 3;

	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SOLVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

	localparam logic KIND_SOLVE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_EPSILON    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SWEEPS = 1'b1;

	localparam logic [CFG_W-1:0] EPSILON_RST    = 16'd66;
	localparam logic [CFG_W-1:0] MAX_SWEEPS_RST = 16'hFFFF;

	localparam logic [PH_W-1:0] PH_NORTH  = 3'd0;
	localparam logic [PH_W-1:0] PH_SOUTH  = 3'd1;
	localparam logic [PH_W-1:0] PH_WEST   = 3'd2;
	localparam logic [PH_W-1:0] PH_EAST   = 3'd3;
	localparam logic [PH_W-1:0] PH_CENTER = 3'd4;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_RD_WAIT = 7'b0000010,
		ST_SWEEP   = 7'b0000100,
		ST_DRAIN   = 7'b0001000,
		ST_COPY    = 7'b0010000,
		ST_CHECK   = 7'b0100000,
		ST_DONE    = 7'b1000000
	} state_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic center;
		logic clear_max;
	} stn_ctrl_t;

endpackage
`default_nettype wire

/* rtl/jacobi_heat_grid_solver_core.sv */
`default_nettype none
// ============================================================================
// jacobi_heat_grid_solver_core: Jacobi heat grid solver
// Holds a square Q16.16 temperature grid in two RAMs and relaxes it with
// five-point Jacobi sweeps until the largest change falls to epsilon or the sweep cap is reached.
// ============================================================================
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+----------------------------------
//  cfg     | in        | cfg_we              | cfg_index, cfg_data
//  in      | in        | in_valid / in_stall | action, row, col, cell_value
//  out     | out       | out_valid/out_stall | kind, value_out, sweep_count,
//          |           |                     | converged, last_max_change
//
// A cell write request is written as it is accepted, so writes stream one
// per cycle while the core is idle. A read passes through the registered
// RAM port into the result registers once the output is free. A solve makes
// five current-grid RAM reads per interior cell, then copies each cell back.
// Input stalls while a read or solve is in progress; a waiting result stalls
// only the completion of the next read or solve. Reset needs no clearing pass.
module jacobi_heat_grid_solver_core
	import jhg_pkg::*;
#(
	parameter int GRID_SIZE = GRID_SIZE_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [ACT_W-1:0]     action,
	input  wire logic [RC_W-1:0]      row,
	input  wire logic [RC_W-1:0]      col,
	input  wire logic [CELL_W-1:0]    cell_value,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      kind,
	output logic      [CELL_W-1:0]    value_out,
	output logic      [CNT_W-1:0]     sweep_count,
	output logic                      converged,
	output logic      [CELL_W-1:0]    last_max_change
);

	localparam int CELLS = GRID_SIZE * GRID_SIZE;
	localparam int AW    = $clog2(CELLS);
	localparam int RCW   = $clog2(GRID_SIZE);

	state_t            state_q;
	logic [CFG_W-1:0]  epsilon_q;
	logic [CFG_W-1:0]  max_sweeps_q;
	logic [RCW-1:0]    r_q;
	logic [RCW-1:0]    c_q;
	logic [AW-1:0]     k_q;
	logic [PH_W-1:0]   ph_q;
	logic              drain_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              conv_q;
	logic              inside_q;
	logic              copy_v_s1;
	logic [AW-1:0]     copy_addr_s1;
	stn_ctrl_t         ctrl_c;
	stn_ctrl_t         ctrl_s1;
	logic [AW-1:0]     addr_s1;

	logic              in_acc;
	logic              out_free;
	logic              load_rd;
	logic              load_sv;
	logic              host_inside;
	logic [31:0]       host_idx;
	logic [AW-1:0]     host_addr;
	logic              row_end;
	logic              last_cell;
	logic [AW-1:0]     k_next;
	logic [AW-1:0]     tap_addr;
	logic [CNT_W-1:0]  cnt_inc;
	logic              conv_c;
	logic              cap_c;
	logic              solve_start;

	logic              cur_we;
	logic [AW-1:0]     cur_waddr;
	logic [CELL_W-1:0] cur_wdata;
	logic              cur_re;
	logic [AW-1:0]     cur_raddr;
	logic [CELL_W-1:0] cur_rdata;
	logic              nxt_we;
	logic [AW-1:0]     nxt_waddr;
	logic [CELL_W-1:0] nxt_wdata;
	logic [CELL_W-1:0] nxt_rdata;
	logic [CELL_W-1:0] max_change;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign load_rd  = (state_q == ST_RD_WAIT) && out_free;
	assign load_sv  = (state_q == ST_DONE) && out_free;

	assign host_inside = (32'(row) < 32'(GRID_SIZE)) && (32'(col) < 32'(GRID_SIZE));
	assign host_idx    = 32'(row) * 32'(GRID_SIZE) + 32'(col);
	assign host_addr   = host_idx[AW-1:0];

	assign row_end   = (c_q == RCW'(GRID_SIZE - 2));
	assign last_cell = row_end && (r_q == RCW'(GRID_SIZE - 2));
	assign k_next    = row_end ? k_q + AW'(3) : k_q + AW'(1);

	always_comb begin
		unique case (ph_q)
			PH_NORTH: tap_addr = k_q - AW'(GRID_SIZE);
			PH_SOUTH: tap_addr = k_q + AW'(GRID_SIZE);
			PH_WEST:  tap_addr = k_q - AW'(1);
			PH_EAST:  tap_addr = k_q + AW'(1);
			default:  tap_addr = k_q;
		endcase
	end

	assign cnt_inc     = cnt_q + CNT_W'(1);
	assign conv_c      = (max_change <= CELL_W'(epsilon_q));
	assign cap_c       = (cnt_inc >= max_sweeps_q);
	assign solve_start = in_acc && (action == ACT_SOLVE);

	assign ctrl_c.valid     = (state_q == ST_SWEEP);
	assign ctrl_c.first     = (ph_q == PH_NORTH);
	assign ctrl_c.center    = (ph_q == PH_CENTER);
	assign ctrl_c.clear_max = solve_start || ((state_q == ST_CHECK) && !conv_c && !cap_c);

	// The current grid takes host writes when idle and copy-back writes during the copy pass.
	assign cur_we    = (in_acc && (action == ACT_WRITE) && host_inside) || copy_v_s1;
	assign cur_waddr = copy_v_s1 ? copy_addr_s1 : host_addr;
	assign cur_wdata = copy_v_s1 ? nxt_rdata : cell_value;
	assign cur_re    = (in_acc && (action == ACT_READ)) || (state_q == ST_SWEEP);
	assign cur_raddr = (state_q == ST_SWEEP) ? tap_addr : host_addr;

	jhg_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cur_waddr),
		.wdata (cur_wdata),
		.re    (cur_re),
		.raddr (cur_raddr),
		.rdata (cur_rdata)
	);

	jhg_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_nxt_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.re    (state_q == ST_COPY),
		.raddr (k_q),
		.rdata (nxt_rdata)
	);

	jhg_stencil #(
		.ADDR_W (AW)
	) u_stencil (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl_s1),
		.addr       (addr_s1),
		.rd_data    (cur_rdata),
		.wr_en      (nxt_we),
		.wr_addr    (nxt_waddr),
		.wr_data    (nxt_wdata),
		.max_change (max_change)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q    <= EPSILON_RST;
			max_sweeps_q <= MAX_SWEEPS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EPSILON:    epsilon_q    <= cfg_data;
				REG_MAX_SWEEPS: max_sweeps_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1      <= k_q;
		copy_addr_s1 <= k_q;
		if (in_acc) begin
			inside_q <= host_inside;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			r_q       <= RCW'(1);
			c_q       <= RCW'(1);
			k_q       <= AW'(GRID_SIZE + 1);
			ph_q      <= PH_NORTH;
			drain_q   <= 1'b0;
			cnt_q     <= '0;
			conv_q    <= 1'b0;
			copy_v_s1 <= 1'b0;
			ctrl_s1   <= '0;
		end else begin
			copy_v_s1 <= (state_q == ST_COPY);
			ctrl_s1   <= ctrl_c;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (action == ACT_READ)) begin
						state_q <= ST_RD_WAIT;
					end else if (solve_start) begin
						state_q <= ST_SWEEP;
						cnt_q   <= '0;
						conv_q  <= 1'b0;
						r_q     <= RCW'(1);
						c_q     <= RCW'(1);
						k_q     <= AW'(GRID_SIZE + 1);
						ph_q    <= PH_NORTH;
					end
				end
				ST_RD_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (ph_q == PH_CENTER) begin
						ph_q <= PH_NORTH;
						if (last_cell) begin
							state_q <= ST_DRAIN;
							drain_q <= 1'b0;
						end else begin
							c_q <= row_end ? RCW'(1) : c_q + RCW'(1);
							r_q <= row_end ? r_q + RCW'(1) : r_q;
							k_q <= k_next;
						end
					end else begin
						ph_q <= ph_q + PH_W'(1);
					end
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= ST_COPY;
						r_q     <= RCW'(1);
						c_q     <= RCW'(1);
						k_q     <= AW'(GRID_SIZE + 1);
					end
				end
				ST_COPY: begin
					if (last_cell) begin
						state_q <= ST_CHECK;
					end else begin
						c_q <= row_end ? RCW'(1) : c_q + RCW'(1);
						r_q <= row_end ? r_q + RCW'(1) : r_q;
						k_q <= k_next;
					end
				end
				ST_CHECK: begin
					r_q  <= RCW'(1);
					c_q  <= RCW'(1);
					k_q  <= AW'(GRID_SIZE + 1);
					ph_q <= PH_NORTH;
					if (conv_c) begin
						conv_q  <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						cnt_q   <= cnt_inc;
						state_q <= cap_c ? ST_DONE : ST_SWEEP;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_rd || load_sv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rd) begin
			kind            <= KIND_READ;
			value_out       <= inside_q ? cur_rdata : '0;
			sweep_count     <= '0;
			converged       <= 1'b0;
			last_max_change <= '0;
		end else if (load_sv) begin
			kind            <= KIND_SOLVE;
			value_out       <= '0;
			sweep_count     <= cnt_q;
			converged       <= conv_q;
			last_max_change <= max_change;
		end
	end

endmodule
`default_nettype wire

/* rtl/jhg_ram.sv */
`default_nettype none
// ============================================================================
// jhg_ram: generic simple dual-port RAM
// One write port and one read port with a registered read that holds its
// data while the read enable is low.
// ============================================================================
module jhg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/jhg_stencil.sv */
`default_nettype none
// ============================================================================
// jhg_stencil: five-point stencil datapath
// Accumulates the four neighbor taps, forms the floored mean, subtracts the
// center tap and keeps the largest absolute change of the sweep.
// ============================================================================
module jhg_stencil
	import jhg_pkg::*;
#(
	parameter int ADDR_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire stn_ctrl_t         ctrl,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [CELL_W-1:0] rd_data,
	output logic                   wr_en,
	output logic      [ADDR_W-1:0] wr_addr,
	output logic      [CELL_W-1:0] wr_data,
	output logic      [CELL_W-1:0] max_change
);

	logic [SUM_W-1:0]  tap_ext;
	logic [SUM_W-1:0]  sum_q;
	logic [CELL_W-1:0] mean_c;
	logic [CELL_W:0]   diff_c;
	logic              v_s2;
	logic [CELL_W-1:0] mean_s2;
	logic [CELL_W:0]   diff_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [CELL_W:0]   abs_c;
	logic [CELL_W-1:0] max_q;

	assign tap_ext = {{(SUM_W-CELL_W){rd_data[CELL_W-1]}}, rd_data};

	// Dropping the two low bits of the sum is an arithmetic shift, i.e. floor division.
	assign mean_c = sum_q[SUM_W-1:2];
	assign diff_c = {mean_c[CELL_W-1], mean_c} - {rd_data[CELL_W-1], rd_data};
	assign abs_c  = diff_s2[CELL_W] ? (~diff_s2 + (CELL_W+1)'(1)) : diff_s2;

	always_ff @(posedge clk) begin
		if (ctrl.valid && !ctrl.center) begin
			sum_q <= ctrl.first ? tap_ext : sum_q + tap_ext;
		end
		mean_s2 <= mean_c;
		diff_s2 <= diff_c;
		addr_s2 <= addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			max_q <= '0;
		end else begin
			v_s2 <= ctrl.valid && ctrl.center;
			if (ctrl.clear_max) begin
				max_q <= '0;
			end else if (v_s2 && (abs_c[CELL_W-1:0] > max_q)) begin
				max_q <= abs_c[CELL_W-1:0];
			end
		end
	end

	assign wr_en      = v_s2;
	assign wr_addr    = addr_s2;
	assign wr_data    = mean_s2;
	assign max_change = max_q;

endmodule
`default_nettype wire

/* rtl/jhg_checker.sv */
`default_nettype none
// ============================================================================
// jhg_checker: port-level checks of the Jacobi heat grid solver
// Watches the request and result channels of the top level over time.
// ============================================================================
module jhg_checker
	import jhg_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic [ACT_W-1:0]     action,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic                 kind,
	input wire logic [CELL_W-1:0]    value_out,
	input wire logic [CNT_W-1:0]     sweep_count,
	input wire logic                 converged,
	input wire logic [CELL_W-1:0]    last_max_change
);

	// A read or solve request stalls the input in the cycle after it is taken.
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && ((action == ACT_SOLVE) || (action == ACT_READ))
		|=> in_stall)
		else $error("read or solve request did not stall the input");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall
		|=> out_valid && $stable(kind) && $stable(value_out) && $stable(sweep_count)
			&& $stable(converged) && $stable(last_max_change))
		else $error("stalled result changed");

	a_read_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_READ)
		|-> (sweep_count == '0) && !converged && (last_max_change == '0))
		else $error("read result carries solve fields");

	// A solve that stops on the cap has counted at least one sweep.
	a_solve_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_SOLVE)
		|-> (value_out == '0) && (converged || (sweep_count != '0)))
		else $error("solve result fields inconsistent");

endmodule

bind jacobi_heat_grid_solver_core jhg_checker u_jhg_checker (.*);
`default_nettype wire

/* bench/tb_jacobi_heat_grid_solver_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_jacobi_heat_grid_solver_core: self-checking bench of the Jacobi solver
// Loads temperature grids cell by cell, runs solves under changing epsilon
// and sweep caps, and reads cells back. A scoreboard relaxes its own copy of
// the grid and compares every result field by field, under random idling on
// both channels and one long hold-off of the result channel.
// ============================================================================
import jhg_pkg::*;

typedef struct packed {
	logic              kind;
	logic [CELL_W-1:0] value;
	logic [CNT_W-1:0]  sweeps;
	logic              conv;
	logic [CELL_W-1:0] change;
} heat_result_t;

class heat_grid_scoreboard;
	localparam int N = GRID_SIZE_DEF;

	logic [CELL_W-1:0] cells [N*N];
	logic [CFG_W-1:0]  eps;
	logic [CFG_W-1:0]  cap;
	heat_result_t      expected [$];
	int                errors;

	function new();
		foreach (cells[i]) cells[i] = '0;
		eps = EPSILON_RST;
		cap = MAX_SWEEPS_RST;
		errors = 0;
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		if (idx == REG_EPSILON)
			eps = data;
		else
			cap = data;
	endfunction

	function logic signed [SUM_W-1:0] widen(logic [CELL_W-1:0] v);
		return {{(SUM_W-CELL_W){v[CELL_W-1]}}, v};
	endfunction

	// One sweep over the interior; returns the largest absolute change.
	function logic [CELL_W-1:0] relax_once();
		logic [CELL_W-1:0]       fresh [N*N];
		logic signed [SUM_W-1:0] sum;
		logic signed [SUM_W-1:0] mean;
		logic signed [SUM_W-1:0] diff;
		logic signed [SUM_W-1:0] mag;
		logic [CELL_W-1:0]       worst;
		int                      k;
		worst = '0;
		fresh = cells;
		for (int r = 1; r < N - 1; r++) begin
			for (int c = 1; c < N - 1; c++) begin
				k = r * N + c;
				sum = widen(cells[k-N]) + widen(cells[k+N]) + widen(cells[k-1])
					+ widen(cells[k+1]);
				mean = sum >>> 2;
				diff = mean - widen(cells[k]);
				mag = (diff < 0) ? -diff : diff;
				fresh[k] = mean[CELL_W-1:0];
				if (mag[CELL_W-1:0] > worst)
					worst = mag[CELL_W-1:0];
			end
		end
		cells = fresh;
		return worst;
	endfunction

	function void note_request(logic [ACT_W-1:0] act, logic [RC_W-1:0] r,
		logic [RC_W-1:0] c, logic [CELL_W-1:0] v);
		heat_result_t      res;
		logic [CNT_W-1:0]  count;
		logic [CELL_W-1:0] change;
		logic              conv;
		res = '0;
		if (act == ACT_WRITE) begin
			cells[r * N + c] = v;
		end else if (act == ACT_SOLVE) begin
			count = '0;
			conv = 1'b0;
			while (1) begin
				change = relax_once();
				if (change <= {16'd0, eps}) begin
					conv = 1'b1;
					break;
				end
				count = count + 1'b1;
				if (count >= cap)
					break;
			end
			res.kind = KIND_SOLVE;
			res.sweeps = count;
			res.conv = conv;
			res.change = change;
			expected.push_back(res);
		end else if (act == ACT_READ) begin
			res.kind = KIND_READ;
			res.value = cells[r * N + c];
			expected.push_back(res);
		end
	endfunction

	function void check_result(logic kind, logic [CELL_W-1:0] value,
		logic [CNT_W-1:0] sweeps, logic conv, logic [CELL_W-1:0] change);
		heat_result_t want;
		if (expected.size() == 0) begin
			$error("result with no request waiting: kind %0d value %h", kind, value);
			errors++;
			return;
		end
		want = expected.pop_front();
		if (kind !== want.kind) begin
			$error("kind: expected %0d, actual %0d", want.kind, kind);
			errors++;
		end
		if (value !== want.value) begin
			$error("value_out: expected %h, actual %h", want.value, value);
			errors++;
		end
		if (sweeps !== want.sweeps) begin
			$error("sweep_count: expected %0d, actual %0d", want.sweeps, sweeps);
			errors++;
		end
		if (conv !== want.conv) begin
			$error("converged: expected %0d, actual %0d", want.conv, conv);
			errors++;
		end
		if (change !== want.change) begin
			$error("last_max_change: expected %h, actual %h", want.change, change);
			errors++;
		end
	endfunction

	function int pending();
		return expected.size();
	endfunction
endclass

module tb_jacobi_heat_grid_solver_core;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1450;
	localparam int QUIET_LIMIT = 60000;
	localparam int HOLD_CYCLES = 300;
	localparam int N = GRID_SIZE_DEF;

	typedef enum int {FILL_FULL, FILL_NARROW, FILL_SMOOTH, FILL_FLAT} fill_mode_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [ACT_W-1:0]     action = ACT_WRITE;
	logic [RC_W-1:0]      row = '0;
	logic [RC_W-1:0]      col = '0;
	logic [CELL_W-1:0]    cell_value = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 kind;
	logic [CELL_W-1:0]    value_out;
	logic [CNT_W-1:0]     sweep_count;
	logic                 converged;
	logic [CELL_W-1:0]    last_max_change;

	heat_grid_scoreboard book = new();

	int         send_idle_pct = 13;
	int         recv_idle_pct = 76;
	int         n_items = 0;
	int         quiet = 0;
	int         hold_left = 0;
	bit         hold_request = 1'b0;
	bit         held = 1'b0;
	bit         wide_cap;
	fill_mode_t mode;
	logic [CELL_W-1:0] base;
	logic [CFG_W-1:0]  eps;
	logic [CFG_W-1:0]  cap;

	jacobi_heat_grid_solver_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.row             (row),
		.col             (col),
		.cell_value      (cell_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.value_out       (value_out),
		.sweep_count     (sweep_count),
		.converged       (converged),
		.last_max_change (last_max_change)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result side: random stall, with one long hold-off counted here.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0)
			book.check_result(kind, value_out, sweep_count, converged, last_max_change);
	end

	always @(negedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("jacobi_heat_grid_solver_core verification failed");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [ACT_W-1:0] act, input logic [RC_W-1:0] r,
		input logic [RC_W-1:0] c, input logic [CELL_W-1:0] v);
		bit taken;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		row <= r;
		col <= c;
		cell_value <= v;
		do begin
			@(negedge clk);
			taken = (in_stall === 1'b0);
			@(posedge clk);
		end while (!taken);
		book.note_request(act, r, c, v);
		if (act != ACT_UNUSED)
			n_items++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		book.set_reg(idx, data);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		cfg_we <= 1'b0;
		while (book.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [CELL_W-1:0] pick_cell(input fill_mode_t m,
		input logic [CELL_W-1:0] b);
		case (m)
			FILL_NARROW: return 32'($urandom_range(0, 32767)) - 32'd16384;
			FILL_SMOOTH: return b + 32'($urandom_range(0, 127)) - 32'd64;
			FILL_FLAT:   return b;
			default: begin
				case ($urandom_range(0, 7))
					0:       return 32'h8000_0000;
					1:       return 32'h7FFF_FFFF;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	task automatic fill_grid(input fill_mode_t m, input logic [CELL_W-1:0] b,
		input bit keep_corners);
		for (int r = 0; r < N; r++) begin
			for (int c = 0; c < N; c++) begin
				if (!(keep_corners && (r == 0 || r == N - 1) && (c == 0 || c == N - 1)))
					send_request(ACT_WRITE, 4'(r), 4'(c), pick_cell(m, b));
			end
		end
	endtask

	task automatic mixed_traffic(input int count, input fill_mode_t m,
		input logic [CELL_W-1:0] b);
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				send_request(ACT_WRITE, 4'($urandom), 4'($urandom), pick_cell(m, b));
			else if (pick < 95)
				send_request(ACT_READ, 4'($urandom), 4'($urandom), $urandom);
			else
				send_request(ACT_UNUSED, 4'($urandom), 4'($urandom), $urandom);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extreme values in the corners, which no sweep uses, read straight back.
		send_request(ACT_WRITE, 4'd0, 4'd0, 32'h8000_0000);
		send_request(ACT_WRITE, 4'd15, 4'd15, 32'h7FFF_FFFF);
		send_request(ACT_WRITE, 4'd0, 4'd15, 32'h0000_0000);
		send_request(ACT_WRITE, 4'd15, 4'd0, 32'hFFFF_FFFF);
		send_request(ACT_READ, 4'd0, 4'd0, 32'hFFFF_FFFF);
		send_request(ACT_READ, 4'd15, 4'd15, 32'h0);
		send_request(ACT_READ, 4'd0, 4'd15, 32'h0);
		send_request(ACT_READ, 4'd15, 4'd0, 32'h0);
		send_request(ACT_UNUSED, 4'd7, 4'd7, $urandom);

		// A flat grid converges on the first sweep even at the reset settings.
		fill_grid(FILL_FLAT, 32'h0001_0000, 1'b1);
		send_request(ACT_SOLVE, 4'd0, 4'd0, 32'h0);
		send_request(ACT_READ, 4'd1, 4'd1, 32'h0);
		send_request(ACT_READ, 4'd8, 4'd8, 32'h0);
		send_request(ACT_WRITE, 4'd5, 4'd5, 32'h7FFF_FFFF);
		send_request(ACT_WRITE, 4'd6, 4'd6, 32'h8000_0000);

		// A sweep cap of zero behaves like a cap of one.
		wait_idle();
		write_reg(REG_MAX_SWEEPS, 16'd0);
		write_reg(REG_EPSILON, 16'd0);
		cfg_we <= 1'b0;
		send_request(ACT_SOLVE, 4'd3, 4'd9, $urandom);
		send_request(ACT_READ, 4'd5, 4'd5, 32'h0);
		send_request(ACT_READ, 4'd4, 4'd5, 32'h0);

		wait_idle();
		write_reg(REG_MAX_SWEEPS, 16'd1);
		write_reg(REG_EPSILON, 16'hFFFF);
		cfg_we <= 1'b0;
		send_request(ACT_SOLVE, 4'd15, 4'd15, 32'hFFFF_FFFF);

		wait_idle();
		write_reg(REG_MAX_SWEEPS, 16'd3);
		write_reg(REG_EPSILON, EPSILON_RST);
		cfg_we <= 1'b0;
		send_request(ACT_SOLVE, 4'd0, 4'd0, 32'h0);
		send_request(ACT_READ, 4'd6, 4'd6, 32'h0);

		while (n_items < ITEM_TARGET) begin
			wait_idle();
			if (n_items < ITEM_TARGET / 3) begin
				send_idle_pct = 13;
				recv_idle_pct = 76;
			end else if (n_items < 2 * ITEM_TARGET / 3) begin
				send_idle_pct = 76;
				recv_idle_pct = 13;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			mode = fill_mode_t'($urandom_range(0, 3));
			base = $urandom;
			// A high cap is only safe when every change must fall under epsilon.
			wide_cap = (mode == FILL_NARROW) && ($urandom_range(0, 1) == 1);
			if (wide_cap) begin
				eps = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(32768, 65535));
				cap = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(2, 65535));
			end else begin
				case ($urandom_range(0, 3))
					0:       eps = 16'd0;
					1:       eps = 16'hFFFF;
					2:       eps = 16'($urandom_range(0, 255));
					default: eps = 16'($urandom);
				endcase
				cap = 16'($urandom_range(0, 6));
			end
			write_reg(REG_EPSILON, eps);
			write_reg(REG_MAX_SWEEPS, cap);
			cfg_we <= 1'b0;
			if (wide_cap || mode == FILL_FLAT || $urandom_range(0, 2) == 0)
				fill_grid(mode, base, 1'b0);
			if (!held && n_items > 2 * ITEM_TARGET / 3) begin
				held = 1'b1;
				hold_request = 1'b1;
			end
			repeat ($urandom_range(1, 3)) begin
				mixed_traffic($urandom_range(4, 40), mode, base);
				send_request(ACT_SOLVE, 4'($urandom), 4'($urandom), $urandom);
				mixed_traffic($urandom_range(0, 4), mode, base);
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (book.errors == 0 && book.pending() == 0)
			$display("jacobi_heat_grid_solver_core verification clean");
		else
			$display("jacobi_heat_grid_solver_core verification failed");
		$finish;
	end

endmodule
